// ===== design/kct_pkg.sv =====
// Shared types and constants of the keyframe curve table.
package kct_pkg;

  // Request kinds carried by the req_type field.
  typedef enum logic [1:0] {
    REQ_ADD_LINEAR = 2'd0,
    REQ_ADD_STEP   = 2'd1,
    REQ_REMOVE     = 2'd2,
    REQ_GET        = 2'd3
  } req_e;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Kind bit of a stored key.
  localparam logic KIND_LINEAR = 1'b0;
  localparam logic KIND_STEP   = 1'b1;

  // Widths of the interpolation datapath.
  localparam int unsigned DIFF_W = 33;  // value difference
  localparam int unsigned PROD_W = 50;  // signed product of difference and frame offset
  localparam int unsigned MAG_W  = 49;  // magnitude of that product

  // One stored keyframe.
  typedef struct packed {
    logic               kind;
    logic [15:0]        frame;
    logic signed [31:0] value;
  } key_entry_t;

  localparam int unsigned ENTRY_W = $bits(key_entry_t);

endpackage

// ===== design/kct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/keyframe_curve_table_unit.sv =====
// Keyframe curve table: sorted keyframe store with range removal and interpolation.
//
// Input channel (in_valid_i / in_stall_o) takes one request item: add a linear
// key, add a step key, remove a frame range, or get the curve value at a frame.
// Output channel (out_valid_o / out_stall_i) returns one result item per request.
// The block works on one request at a time; in_stall_o is high while a request
// is in progress. The result sits in an output register, so the next request is
// taken while an earlier result still waits for the receiver.
// All keys live in one RAM with a registered read. A request scans the table
// from entry zero, one entry at a time, unless it skips the scan as below.
// An add scans to its slot and moves the later keys up one by one.
// A removal scans from entry zero to the start of the range, continues on to
// its end and moves the surviving tail down.
// A get that lands between two keys, the upper one linear and at another frame,
// adds a multiply step, a step to take the magnitude, a restoring divider over
// the 49-bit magnitude and a final add.
// A rejected add, or a get or removal on an empty table, skips the scan and goes
// straight to the result.
// The next request is taken in the cycle after the result is presented.
// Reset empties the table at once (count and largest frame go to zero); the RAM
// is not cleared, since entries beyond the count are never read.
// When the receiver stalls, the finished result holds and the block waits
// before presenting the next result.
module keyframe_curve_table_unit #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        frame_i,
  input  logic signed [31:0] key_value_i,
  input  logic [15:0]        frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         key_count_o,
  output logic [15:0]        max_frame_seen_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned DIV_STEPS = kct_pkg::MAG_W;
  localparam int unsigned DCW = $clog2(DIV_STEPS + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCHK = 4'd2;
  localparam logic [3:0] S_POST = 4'd3;
  localparam logic [3:0] S_SU   = 4'd4;
  localparam logic [3:0] S_SUW  = 4'd5;
  localparam logic [3:0] S_CP   = 4'd6;
  localparam logic [3:0] S_CPW  = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ABS  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [15:0]   largest_q, largest_d;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] src_q, src_d;
  logic          phase_q, phase_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  // Payload registers.
  kct_pkg::req_e       op_q, op_d;
  logic [15:0]         f_q, f_d;
  logic signed [31:0]  val_q, val_d;
  logic [15:0]         fe_q, fe_d;
  logic [15:0]         thr_q, thr_d;
  kct_pkg::key_entry_t cur_q, cur_d;
  kct_pkg::key_entry_t prev_q, prev_d;
  logic signed [kct_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [kct_pkg::MAG_W-1:0] dvd_q, dvd_d;
  logic [15:0]         rem_q, rem_d;
  logic                neg_q, neg_d;
  logic signed [31:0]  res_q, res_d;
  logic [1:0]          stat_q, stat_d;
  logic signed [31:0]  out_res_q, out_res_d;
  logic [1:0]          out_stat_q, out_stat_d;
  logic [CW-1:0]       out_cnt_q, out_cnt_d;
  logic [15:0]         out_max_q, out_max_d;

  // RAM port signals.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  kct_pkg::key_entry_t   ram_wdata;
  logic [AW-1:0]         ram_raddr;
  kct_pkg::key_entry_t   ram_rdata;
  logic [kct_pkg::ENTRY_W-1:0] ram_rbits;

  kct_ram #(
    .WIDTH(kct_pkg::ENTRY_W),
    .DEPTH(MAX_KEYS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );

  assign ram_rdata = kct_pkg::key_entry_t'(ram_rbits);

  // Interpolation datapath pieces.
  logic signed [kct_pkg::DIFF_W-1:0] dv;
  logic [15:0] d_off;
  logic [15:0] df;
  logic [16:0] rem_sh;
  logic        qbit;

  assign dv = kct_pkg::DIFF_W'(cur_q.value) - kct_pkg::DIFF_W'(prev_q.value);
  assign d_off = f_q - prev_q.frame;
  assign df = cur_q.frame - prev_q.frame;
  assign rem_sh = {rem_q, dvd_q[kct_pkg::MAG_W-1]};
  assign qbit = (rem_sh >= {1'b0, df});

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    largest_d   = largest_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    src_d       = src_q;
    phase_d     = phase_q;
    dcnt_d      = dcnt_q;
    op_d        = op_q;
    f_d         = f_q;
    val_d       = val_q;
    fe_d        = fe_q;
    thr_d       = thr_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    out_cnt_d   = out_cnt_q;
    out_max_d   = out_max_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[AW-1:0];
    ram_wdata   = cur_q;
    ram_raddr   = idx_q[AW-1:0];

    // The receiver takes the pending result.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = kct_pkg::req_e'(req_type_i);
          f_d     = frame_i;
          val_d   = key_value_i;
          fe_d    = frame_end_i;
          thr_d   = frame_i;
          idx_d   = '0;
          phase_d = 1'b0;
          res_d   = '0;
          stat_d  = kct_pkg::ST_OK;
          state_d = S_SRD;
          if (kct_pkg::req_e'(req_type_i) == kct_pkg::REQ_GET && count_q == '0) begin
            stat_d  = kct_pkg::ST_EMPTY;
            state_d = S_OUT;
          end else if (kct_pkg::req_e'(req_type_i) != kct_pkg::REQ_GET &&
                       kct_pkg::req_e'(req_type_i) != kct_pkg::REQ_REMOVE &&
                       count_q >= CW'(MAX_KEYS)) begin
            stat_d  = kct_pkg::ST_FULL;
            state_d = S_OUT;
          end else if (kct_pkg::req_e'(req_type_i) == kct_pkg::REQ_REMOVE &&
                       count_q == '0) begin
            state_d = S_OUT;
          end
        end
      end

      // Scan for the first key whose frame is above the threshold.
      S_SRD: begin
        if (idx_q == count_q) begin
          state_d = S_POST;
        end else begin
          state_d = S_SCHK;
        end
      end

      S_SCHK: begin
        if (ram_rdata.frame > thr_q) begin
          cur_d   = ram_rdata;
          state_d = S_POST;
        end else begin
          prev_d  = ram_rdata;
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end

      // Act on the scan result.
      S_POST: begin
        unique case (op_q)
          kct_pkg::REQ_ADD_LINEAR, kct_pkg::REQ_ADD_STEP: begin
            lo_d    = idx_q;
            src_d   = count_q;
            state_d = S_SU;
          end
          kct_pkg::REQ_REMOVE: begin
            if (!phase_q) begin
              if (idx_q >= count_q) begin
                state_d = S_OUT;
              end else begin
                lo_d    = idx_q;
                thr_d   = fe_q;
                phase_d = 1'b1;
                state_d = S_SRD;
              end
            end else begin
              src_d   = idx_q;
              state_d = S_CP;
              if (idx_q == lo_q) begin
                state_d = S_OUT;
              end
            end
          end
          kct_pkg::REQ_GET: begin
            state_d = S_OUT;
            if (idx_q == '0) begin
              res_d = cur_q.value;
            end else if (idx_q == count_q) begin
              res_d = prev_q.value;
            end else if (cur_q.kind == kct_pkg::KIND_STEP || cur_q.frame == prev_q.frame) begin
              res_d = prev_q.value;
            end else begin
              state_d = S_MUL;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end

      // Insert: move keys at and above the slot up by one, then write the new key.
      S_SU: begin
        if (src_q > lo_q) begin
          ram_raddr = AW'(src_q - 1'b1);
          state_d   = S_SUW;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = lo_q[AW-1:0];
          ram_wdata.frame = f_q;
          ram_wdata.value = val_q;
          ram_wdata.kind  = (op_q == kct_pkg::REQ_ADD_STEP) ? kct_pkg::KIND_STEP
                                                             : kct_pkg::KIND_LINEAR;
          count_d = count_q + 1'b1;
          if (f_q > largest_q) begin
            largest_d = f_q;
          end
          state_d = S_OUT;
        end
      end

      S_SUW: begin
        ram_we    = 1'b1;
        ram_waddr = src_q[AW-1:0];
        ram_wdata = ram_rdata;
        src_d     = src_q - 1'b1;
        state_d   = S_SU;
      end

      // Removal: copy the tail down over the removed run.
      S_CP: begin
        if (src_q < count_q) begin
          ram_raddr = src_q[AW-1:0];
          state_d   = S_CPW;
        end else begin
          count_d = lo_q;
          state_d = S_OUT;
        end
      end

      S_CPW: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[AW-1:0];
        ram_wdata = ram_rdata;
        src_d     = src_q + 1'b1;
        lo_d      = lo_q + 1'b1;
        state_d   = S_CP;
      end

      // Linear blend: product, magnitude, then a bit-serial divide.
      S_MUL: begin
        prod_d  = kct_pkg::PROD_W'(dv * $signed({1'b0, d_off}));
        state_d = S_ABS;
      end

      S_ABS: begin
        neg_d   = prod_q[kct_pkg::PROD_W-1];
        dvd_d   = prod_q[kct_pkg::PROD_W-1] ? kct_pkg::MAG_W'(-prod_q)
                                            : kct_pkg::MAG_W'(prod_q);
        rem_d   = '0;
        dcnt_d  = DCW'(DIV_STEPS);
        state_d = S_DIV;
      end

      S_DIV: begin
        rem_d  = qbit ? 16'(rem_sh - {1'b0, df}) : rem_sh[15:0];
        dvd_d  = {dvd_q[kct_pkg::MAG_W-2:0], qbit};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        res_d   = neg_q ? (prev_q.value - $signed(dvd_q[31:0]))
                        : (prev_q.value + $signed(dvd_q[31:0]));
        state_d = S_OUT;
      end

      // Present the result once the output register is free.
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_stat_d  = stat_q;
          out_cnt_d   = count_q;
          out_max_d   = largest_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      largest_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      lo_q        <= '0;
      src_q       <= '0;
      phase_q     <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      largest_q   <= largest_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      lo_q        <= lo_d;
      src_q       <= src_d;
      phase_q     <= phase_d;
      dcnt_q      <= dcnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    f_q        <= f_d;
    val_q      <= val_d;
    fe_q       <= fe_d;
    thr_q      <= thr_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prod_q     <= prod_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
    out_cnt_q  <= out_cnt_d;
    out_max_q  <= out_max_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_res_q;
  assign status_o         = out_stat_q;
  assign key_count_o      = 7'(out_cnt_q);
  assign max_frame_seen_o = out_max_q;

  // The table never holds more keys than it has room for.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS))
    else $error("key count above table size");

  // An empty-table status always comes with a zero value.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == kct_pkg::ST_EMPTY |-> result_value_o == '0)
    else $error("empty status with nonzero value");

  // Moving keys up writes only inside the grown table.
  a_shift_up_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUW |-> src_q != '0 && src_q <= count_q && count_q < CW'(MAX_KEYS))
    else $error("shift-up write outside table");

  // Copying down never writes ahead of its source.
  a_copy_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CPW |-> lo_q < src_q && src_q < count_q)
    else $error("copy-down order broken");

endmodule
